>>> rtl/mwsa_pkg.sv
package mwsa_pkg;

  // field widths
  localparam int CMD_W  = 15;
  localparam int MEAS_W = 16;
  localparam int CFG_W  = 14;
  localparam int WHL_W  = 17;   // raw wheel sum, signed
  localparam int MAG_W  = 16;   // wheel magnitude
  localparam int TOT_W  = 18;   // sum of four magnitudes
  localparam int BUD_W  = 16;   // 4 * budget
  localparam int PRD_W  = MAG_W + BUD_W;
  localparam int QUO_W  = 16;
  localparam int REF_W  = 15;
  localparam int KIN_W  = 17;
  localparam int ERR_W  = 19;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 136;

  localparam logic [CFG_W-1:0] BUDGET_RESET = 14'd8500;
  localparam logic signed [WHL_W-1:0] REF_CLAMP_HI = 17'sd8500;
  localparam logic signed [WHL_W-1:0] REF_CLAMP_LO = -17'sd8500;

  typedef logic [3:0] step_t;

  // microprogram addresses
  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_SUM   = 4'd1;
  localparam step_t STEP_CHECK = 4'd2;
  localparam step_t STEP_MUL   = 4'd3;
  localparam step_t STEP_DIV0  = 4'd4;
  localparam step_t STEP_WAIT0 = 4'd5;
  localparam step_t STEP_DIV1  = 4'd6;
  localparam step_t STEP_WAIT1 = 4'd7;
  localparam step_t STEP_DIV2  = 4'd8;
  localparam step_t STEP_WAIT2 = 4'd9;
  localparam step_t STEP_DIV3  = 4'd10;
  localparam step_t STEP_WAIT3 = 4'd11;
  localparam step_t STEP_WB3   = 4'd12;
  localparam step_t STEP_CLAMP = 4'd13;
  localparam step_t STEP_KIN   = 4'd14;
  localparam step_t STEP_LOOP  = 4'd15;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_NO_SCALE,
    COND_DIV_BUSY,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_t;

  typedef struct packed {
    logic  load;    // take an input beat, form wheel sums
    logic  sum;     // total of magnitudes
    logic  mul;     // head wheel magnitude * budget, rotate wheels
    logic  dstart;  // start divider on product
    logic  wb;      // push signed quotient into result queue
    logic  clamp;   // clamp all wheels
    logic  kin;     // kinematics, error, output register
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic no_scale;
    logic div_busy;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    begin
      w = '0;
      w.cond = COND_NEVER;
      w.target = STEP_IDLE;
      case (step)
        STEP_IDLE: begin
          w.load = 1'b1;
          w.cond = COND_NO_INPUT;
          w.target = STEP_IDLE;
        end
        STEP_SUM: begin
          w.sum = 1'b1;
        end
        STEP_CHECK: begin
          w.cond = COND_NO_SCALE;
          w.target = STEP_CLAMP;
        end
        STEP_MUL: begin
          w.mul = 1'b1;
        end
        STEP_DIV0: begin
          w.dstart = 1'b1;
          w.mul = 1'b1;
        end
        STEP_WAIT0: begin
          w.cond = COND_DIV_BUSY;
          w.target = STEP_WAIT0;
        end
        STEP_DIV1: begin
          w.wb = 1'b1;
          w.dstart = 1'b1;
          w.mul = 1'b1;
        end
        STEP_WAIT1: begin
          w.cond = COND_DIV_BUSY;
          w.target = STEP_WAIT1;
        end
        STEP_DIV2: begin
          w.wb = 1'b1;
          w.dstart = 1'b1;
          w.mul = 1'b1;
        end
        STEP_WAIT2: begin
          w.cond = COND_DIV_BUSY;
          w.target = STEP_WAIT2;
        end
        STEP_DIV3: begin
          w.wb = 1'b1;
          w.dstart = 1'b1;
        end
        STEP_WAIT3: begin
          w.cond = COND_DIV_BUSY;
          w.target = STEP_WAIT3;
        end
        STEP_WB3: begin
          w.wb = 1'b1;
        end
        STEP_CLAMP: begin
          w.clamp = 1'b1;
        end
        STEP_KIN: begin
          w.kin = 1'b1;
          w.cond = COND_OUT_BUSY;
          w.target = STEP_KIN;
        end
        STEP_LOOP: begin
          w.cond = COND_ALWAYS;
          w.target = STEP_IDLE;
        end
        default: begin
          w.cond = COND_ALWAYS;
          w.target = STEP_IDLE;
        end
      endcase
      return w;
    end
  endfunction

endpackage

>>> rtl/mwsa_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
// Caller guarantees quotient fits QUO_W bits (dividend < divisor << QUO_W).
module mwsa_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mwsa_pkg::PRD_W-1:0]      dividend,
  input  logic [mwsa_pkg::TOT_W-1:0]      divisor,
  output logic                            busy,
  output logic [mwsa_pkg::QUO_W-1:0]      quotient
);

  localparam int QW    = mwsa_pkg::QUO_W;
  localparam int DW    = mwsa_pkg::TOT_W;
  localparam int ITERS = QW / 2;
  localparam int CW    = $clog2(ITERS + 1);

  logic [DW-1:0] rem;
  logic [QW-1:0] sh;     // low dividend bits in, quotient bits out
  logic [CW-1:0] cnt;

  logic [DW:0]   t1, t2;
  logic          ge1, ge2;
  logic [DW-1:0] r1, r2;

  always_comb begin
    t1  = {rem, sh[QW-1]};
    ge1 = t1 >= {1'b0, divisor};
    r1  = ge1 ? DW'(t1 - {1'b0, divisor}) : t1[DW-1:0];
    t2  = {r1, sh[QW-2]};
    ge2 = t2 >= {1'b0, divisor};
    r2  = ge2 ? DW'(t2 - {1'b0, divisor}) : t2[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(ITERS);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(dividend[mwsa_pkg::PRD_W-1:QW]);
      sh  <= dividend[QW-1:0];
    end else if (cnt != '0) begin
      rem <= r2;
      sh  <= {sh[QW-3:0], ge1, ge2};
    end
  end

  // last step still in flight at cnt == 1: result is ready for the next step
  assign busy     = cnt > CW'(1);
  assign quotient = sh;

endmodule

>>> rtl/mwsa_seq.sv
// Microprogram sequencer: step counter, control ROM, conditional jump.
module mwsa_seq (
  input  logic                clk,
  input  logic                rst,
  input  mwsa_pkg::status_t   status,
  output mwsa_pkg::ctrl_t     ctrl
);

  mwsa_pkg::step_t pc, pc_next;
  logic            take;

  assign ctrl = mwsa_pkg::ucode(pc);

  always_comb begin
    case (ctrl.cond)
      mwsa_pkg::COND_NEVER:    take = 1'b0;
      mwsa_pkg::COND_NO_INPUT: take = !status.in_valid;
      mwsa_pkg::COND_NO_SCALE: take = status.no_scale;
      mwsa_pkg::COND_DIV_BUSY: take = status.div_busy;
      mwsa_pkg::COND_OUT_BUSY: take = status.out_busy;
      mwsa_pkg::COND_ALWAYS:   take = 1'b1;
      default:                 take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + mwsa_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mwsa_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/mwsa_dp.sv
// Datapath: wheel ring, magnitude total, multiplier, divider, clamp,
// kinematics and output register.
module mwsa_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mwsa_pkg::ctrl_t                       ctrl,
  input  logic [mwsa_pkg::CFG_W-1:0]            max_wheel_speed,
  input  logic                                  s_axis_tvalid,
  input  logic [mwsa_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  input  logic                                  m_axis_tready,
  output logic                                  m_axis_tvalid,
  output logic [mwsa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output mwsa_pkg::status_t                     status
);

  localparam int WW = mwsa_pkg::WHL_W;
  localparam int EW = mwsa_pkg::ERR_W;
  localparam int PW = mwsa_pkg::PRD_W;

  function automatic logic [mwsa_pkg::MAG_W-1:0] mag16(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] n;
    begin
      n = -v;
      mag16 = v[WW-1] ? n[mwsa_pkg::MAG_W-1:0] : v[mwsa_pkg::MAG_W-1:0];
    end
  endfunction

  function automatic logic signed [WW-1:0] clip(input logic signed [WW-1:0] v);
    begin
      if (v > mwsa_pkg::REF_CLAMP_HI) clip = mwsa_pkg::REF_CLAMP_HI;
      else if (v < mwsa_pkg::REF_CLAMP_LO) clip = mwsa_pkg::REF_CLAMP_LO;
      else clip = v;
    end
  endfunction

  // input unpack
  logic signed [WW-1:0] vx, vy, vw;
  logic signed [EW-1:0] m0, m1, m2, m3, fdb_in;

  assign vx = {{2{s_axis_tdata[14]}}, s_axis_tdata[14:0]};
  assign vy = {{2{s_axis_tdata[29]}}, s_axis_tdata[29:15]};
  assign vw = {{2{s_axis_tdata[44]}}, s_axis_tdata[44:30]};
  assign m0 = {{3{s_axis_tdata[60]}}, s_axis_tdata[60:45]};
  assign m1 = {{3{s_axis_tdata[76]}}, s_axis_tdata[76:61]};
  assign m2 = {{3{s_axis_tdata[92]}}, s_axis_tdata[92:77]};
  assign m3 = {{3{s_axis_tdata[108]}}, s_axis_tdata[108:93]};

  // vx+vy+vw of measured speeds, quarter-rpm: m0 - m1 - m2 - 3*m3
  assign fdb_in = m0 - m1 - m2 - {m3[EW-2:0], 1'b0} - m3;

  logic load_fire, kin_fire, out_busy;
  assign load_fire = ctrl.load && s_axis_tvalid;
  assign out_busy  = m_axis_tvalid && !m_axis_tready;
  assign kin_fire  = ctrl.kin && !out_busy;

  logic [mwsa_pkg::BUD_W-1:0] budget;
  assign budget = {max_wheel_speed, 2'b00};

  // wheel ring: FL, FR, BL, BR; mul reads the head and rotates
  logic signed [WW-1:0] w [4];
  logic signed [WW-1:0] res [4];     // scaled wheels, queued in order
  logic [mwsa_pkg::TOT_W-1:0] total;
  logic [mwsa_pkg::PRD_W-1:0] product;
  logic product_neg, div_neg;
  logic signed [EW-1:0] pend_fdb, prev_fdb;

  logic div_busy;
  logic [mwsa_pkg::QUO_W-1:0] quo;
  logic signed [WW-1:0] quo_pos, quo_signed;

  assign quo_pos    = {1'b0, quo};
  assign quo_signed = div_neg ? -quo_pos : quo_pos;

  mwsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.dstart),
    .dividend (product),
    .divisor  (total),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (load_fire) begin
      w[0] <= vx + vy - vw;
      w[1] <= -vx + vy - vw;
      w[2] <= vx - vy - vw;
      w[3] <= -vx - vy - vw;
      pend_fdb <= fdb_in;
    end else if (ctrl.mul) begin
      w[0] <= w[1];
      w[1] <= w[2];
      w[2] <= w[3];
      w[3] <= w[0];
    end else if (ctrl.clamp) begin
      for (int i = 0; i < 4; i++) begin
        w[i] <= clip(status.no_scale ? w[i] : res[i]);
      end
    end
    if (ctrl.sum) begin
      total <= {2'b00, mag16(w[0])} + {2'b00, mag16(w[1])}
             + {2'b00, mag16(w[2])} + {2'b00, mag16(w[3])};
    end
    if (ctrl.mul) begin
      product     <= PW'(mag16(w[0])) * PW'(budget);
      product_neg <= w[0][WW-1];
    end
    if (ctrl.dstart) begin
      div_neg <= product_neg;
    end
    if (ctrl.wb) begin
      res[0] <= res[1];
      res[1] <= res[2];
      res[2] <= res[3];
      res[3] <= quo_signed;
    end
  end

  // kinematics on clamped wheels
  logic signed [WW-1:0] kin_x, kin_y, kin_w;
  logic signed [EW-1:0] err;

  assign kin_x = w[0] - w[1] + w[2] - w[3];
  assign kin_y = w[0] + w[1] - w[2] - w[3];
  assign kin_w = -(w[0] + w[1] + w[2] + w[3]);
  assign err   = {{2{kin_x[WW-1]}}, kin_x} + {{2{kin_y[WW-1]}}, kin_y}
               + {{2{kin_w[WW-1]}}, kin_w} - prev_fdb;

  logic [mwsa_pkg::REF_W-1:0] o_fl, o_fr, o_bl, o_br;
  logic [mwsa_pkg::KIN_W-1:0] o_x, o_y, o_w;
  logic [mwsa_pkg::ERR_W-1:0] o_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      prev_fdb      <= '0;
    end else if (kin_fire) begin
      m_axis_tvalid <= 1'b1;
      prev_fdb      <= pend_fdb;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (kin_fire) begin
      o_fl  <= w[0][mwsa_pkg::REF_W-1:0];
      o_fr  <= w[1][mwsa_pkg::REF_W-1:0];
      o_bl  <= w[2][mwsa_pkg::REF_W-1:0];
      o_br  <= w[3][mwsa_pkg::REF_W-1:0];
      o_x   <= kin_x;
      o_y   <= kin_y;
      o_w   <= kin_w;
      o_err <= err;
    end
  end

  assign m_axis_tdata = {6'b0, o_err, o_w, o_y, o_x, o_br, o_bl, o_fr, o_fl};

  assign status.in_valid = s_axis_tvalid;
  assign status.no_scale = total <= {2'b00, budget};
  assign status.div_busy = div_busy;
  assign status.out_busy = out_busy;

endmodule

>>> rtl/mecanum_wheel_speed_allocator.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    s_axis_tdata[111:0], chassis cmd + motor speeds
// m_axis    out  m_axis_tvalid / m_axis_tready    m_axis_tdata[135:0], wheel refs, kinematics, error
// cfg       in   cfg_valid / cfg_ready            cfg_data[13:0], max_wheel_speed
//
// One item at a time. An item that needs no scaling runs from its input beat
// through the sum, check, clamp, kinematics and loop steps; one that is scaled
// also uses the shared radix-4 divider (a start step plus eight two-bit
// iterations per wheel, four wheels in turn) and one multiplier. A result waiting
// in the output register does not block the next input beat; only the final
// kinematics step waits for it to drain.
// Reset is synchronous and active high: budget returns to 8500, the stored
// feedback sum to zero. cfg_ready is always high.
module mecanum_wheel_speed_allocator (
  input  logic         clk,
  input  logic         rst,
  // cmd_forward[14:0], cmd_lateral[29:15], cmd_rotate[44:30],
  // meas_front_left[60:45], meas_front_right[76:61],
  // meas_back_left[92:77], meas_back_right[108:93], zero pad [111:109]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  // ref_front_left[14:0], ref_front_right[29:15], ref_back_left[44:30],
  // ref_back_right[59:45], ref_vx_quarters[76:60], ref_vy_quarters[93:77],
  // ref_vw_quarters[110:94], speed_error_quarters[129:111], zero pad [135:130]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,
  // max_wheel_speed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data
);

  mwsa_pkg::ctrl_t   ctrl;
  mwsa_pkg::status_t status;

  // per-wheel budget; total budget is four times this
  logic [mwsa_pkg::CFG_W-1:0] max_wheel_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wheel_speed <= mwsa_pkg::BUDGET_RESET;
    end else if (cfg_valid) begin
      max_wheel_speed <= cfg_data;
    end
  end

  // input is taken only at the idle step of the microprogram
  assign s_axis_tready = ctrl.load;

  mwsa_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mwsa_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .max_wheel_speed (max_wheel_speed),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tdata    (m_axis_tdata),
    .status          (status)
  );

endmodule

>>> rtl/mwsa_checker.sv
module mwsa_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  logic signed [14:0] fl, fr, bl, br;
  logic signed [16:0] vw_out, vw_chk;

  assign fl     = m_axis_tdata[14:0];
  assign fr     = m_axis_tdata[29:15];
  assign bl     = m_axis_tdata[44:30];
  assign br     = m_axis_tdata[59:45];
  assign vw_out = m_axis_tdata[110:94];
  assign vw_chk = -(17'(fl) + 17'(fr) + 17'(bl) + 17'(br));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_ref_clamped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> fl <= 15'sd8500 && fl >= -15'sd8500 && fr <= 15'sd8500
      && fr >= -15'sd8500 && bl <= 15'sd8500 && bl >= -15'sd8500
      && br <= 15'sd8500 && br >= -15'sd8500)
    else $error("wheel reference outside clamp");

  a_vw_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> vw_out == vw_chk)
    else $error("vw does not match wheel references");

endmodule

bind mecanum_wheel_speed_allocator mwsa_checker u_chk (.*);
